// ----- rtl/dsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types, constants and the answer record table for the DNS sinkhole
// responder.
// ----------------------------------------------------------------------------
package dsr_pkg;

  localparam int MAX_DATAGRAM_DEF = 584;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 10;
  localparam int BEAT_W   = 5;

  localparam int HDR_LEN        = 12;
  localparam int QUESTION_TAIL  = 5;   // root label, QTYPE, QCLASS
  localparam int ANSWER_LEN     = 16;
  localparam int ANSWER_BEATS   = ANSWER_LEN + 2;
  localparam int ANCOUNT_LO_OFF = 7;

  localparam int FLAGS_HI_OFF = 2;
  localparam int FLAGS_LO_OFF = 3;
  localparam int COUNTS_OFF   = 4;
  localparam int QDCOUNT_LO_OFF = 5;

  localparam logic [7:0] FLAGS_HI = 8'h81;
  localparam logic [7:0] FLAGS_LO = 8'h80;
  localparam logic [7:0] PTR_HI   = 8'hC0;
  localparam logic [7:0] PTR_LO   = 8'h0C;
  localparam logic [7:0] TTL_SEC  = 8'd60;
  localparam logic [7:0] RDLEN_A  = 8'd4;

  localparam logic [15:0] TYPE_A   = 16'd1;
  localparam logic [15:0] TYPE_ANY = 16'd255;
  localparam logic [15:0] CLASS_IN = 16'd1;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_DROP  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_DROP   = 2'd1,
    ACT_SEND   = 2'd2,
    ACT_ANSWER = 2'd3
  } action_t;

  // Work handed from the parser to the emitter for one input byte.
  typedef struct packed {
    logic                has_write;
    logic [OFFSET_W-1:0] wr_offset;
    logic [BYTE_W-1:0]   wr_value;
    action_t             action;
    logic [OFFSET_W-1:0] q_end;
  } job_t;

  // Byte i of the appended A record: name pointer, type, class, TTL, length,
  // address.
  function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                             input logic [31:0] addr);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0:  b = PTR_HI;
      4'd1:  b = PTR_LO;
      4'd2:  b = TYPE_A[15:8];
      4'd3:  b = TYPE_A[7:0];
      4'd4:  b = CLASS_IN[15:8];
      4'd5:  b = CLASS_IN[7:0];
      4'd9:  b = TTL_SEC;
      4'd11: b = RDLEN_A;
      4'd12: b = addr[31:24];
      4'd13: b = addr[23:16];
      4'd14: b = addr[15:8];
      4'd15: b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/dns_sinkhole_responder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_sinkhole_responder
// Rewrites a DNS query, streamed one byte per beat, into a response.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle on s_* while the emitter keeps up, and
// emits offset/value writes on m_* for each byte up to the end of the
// question, with the header rewritten as a response. On the final byte
// (s_tlast) it adds a drop beat, a send beat carrying the response length, or
// for an A/ANY query of class IN the ANCOUNT patch, the 16-byte answer record
// and the send beat. A byte holds the emitter for as many beats as it has:
// one for a byte that only writes, none for a byte past the question or past
// the size limit, one or two for a final byte that sends or drops, 18 or 19
// for a final byte that answers. The input register holds the next byte that
// has beats during that burst. answer_address is loaded through cfg_* and
// should be written only between datagrams; it resets to 0.
// ----------------------------------------------------------------------------
module dns_sinkhole_responder #(
  parameter int MAX_DATAGRAM = dsr_pkg::MAX_DATAGRAM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // is_final
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [9:0] offset, [17:10] value, [27:18] send_length
  output logic [1:0]  m_tuser,    // [1:0] kind
  output logic        m_tlast,    // run_end
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // [31:0] answer_address
);
  import dsr_pkg::*;

  logic [31:0] answer_address;
  logic        job_valid;
  job_t        job;
  logic        job_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= '0;
    end else if (cfg_valid) begin
      answer_address <= cfg_data;
    end
  end

  dsr_parser #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  dsr_emitter u_emitter (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (job_valid),
    .job            (job),
    .job_take       (job_take),
    .answer_address (answer_address),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast)
  );

endmodule

// ----- rtl/dsr_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_parser
// Input register and datagram walker: rewrites header bytes, follows the name
// labels, captures QTYPE/QCLASS and decides the end-of-datagram action.
// ----------------------------------------------------------------------------
module dsr_parser #(
  parameter int MAX_DATAGRAM = dsr_pkg::MAX_DATAGRAM_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,    // [7:0] data_byte
  input  logic          s_tlast,
  output logic          job_valid,
  output dsr_pkg::job_t job,
  input  logic          job_take
);
  import dsr_pkg::*;

  localparam int PW = $clog2(MAX_DATAGRAM + 257);

  logic          in_valid;
  logic [7:0]    in_data;
  logic          in_last;

  logic [PW-1:0] byte_position, byte_position_next;
  logic [PW-1:0] next_label_position, next_label_position_next;
  logic          name_done, name_done_next;
  logic [PW-1:0] question_end, question_end_next;
  logic [15:0]   query_type, query_type_next;
  logic [15:0]   query_class, query_class_next;

  logic          advance;
  logic          has_beats;
  logic [PW-1:0] p;
  logic [PW-1:0] q_gap;
  logic          wr;
  logic [7:0]    v;
  action_t       act;

  always_comb begin
    p                        = byte_position;
    byte_position_next       = byte_position;
    next_label_position_next = next_label_position;
    name_done_next           = name_done;
    question_end_next        = question_end;
    query_type_next          = query_type;
    query_class_next         = query_class;
    wr                       = 1'b0;
    v                        = in_data;
    act                      = ACT_NONE;
    q_gap                    = question_end - p;

    if (p < PW'(MAX_DATAGRAM)) begin
      if (p < PW'(HDR_LEN)) begin
        wr = 1'b1;
        if (p == PW'(FLAGS_HI_OFF)) v = FLAGS_HI;
        else if (p == PW'(FLAGS_LO_OFF)) v = FLAGS_LO;
        else if (p == PW'(QDCOUNT_LO_OFF)) v = 8'd1;
        else if (p >= PW'(COUNTS_OFF)) v = 8'd0;
      end else if (!name_done) begin
        wr = 1'b1;
        if (p == next_label_position) begin
          if (in_data == 8'd0) begin
            name_done_next    = 1'b1;
            question_end_next = p + PW'(QUESTION_TAIL);
          end else begin
            next_label_position_next = p + PW'(in_data) + PW'(1);
          end
        end
      end else if (p < question_end) begin
        wr = 1'b1;
        if (q_gap == PW'(4)) query_type_next[15:8] = in_data;
        else if (q_gap == PW'(3)) query_type_next[7:0] = in_data;
        else if (q_gap == PW'(2)) query_class_next[15:8] = in_data;
        else query_class_next[7:0] = in_data;
      end
      byte_position_next = p + PW'(1);
    end

    if (in_last) begin
      if (byte_position_next < PW'(HDR_LEN) || !name_done_next ||
          question_end_next > byte_position_next) begin
        act = ACT_DROP;
      end else if ((query_type_next == TYPE_A || query_type_next == TYPE_ANY) &&
                   query_class_next == CLASS_IN) begin
        act = ACT_ANSWER;
      end else begin
        act = ACT_SEND;
      end
    end
  end

  always_comb begin
    job.has_write = wr;
    job.wr_offset = OFFSET_W'(p);
    job.wr_value  = v;
    job.action    = act;
    job.q_end     = OFFSET_W'(question_end_next);
  end

  assign has_beats = wr || (act != ACT_NONE);
  assign job_valid = in_valid && has_beats;
  // A byte with nothing to emit retires without waiting on the emitter.
  assign advance   = in_valid && (!has_beats || job_take);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      next_label_position <= PW'(HDR_LEN);
      name_done           <= 1'b0;
      question_end        <= '0;
      query_type          <= '0;
      query_class         <= '0;
    end else if (advance) begin
      if (in_last) begin
        byte_position       <= '0;
        next_label_position <= PW'(HDR_LEN);
        name_done           <= 1'b0;
        question_end        <= '0;
        query_type          <= '0;
        query_class         <= '0;
      end else begin
        byte_position       <= byte_position_next;
        next_label_position <= next_label_position_next;
        name_done           <= name_done_next;
        question_end        <= question_end_next;
        query_type          <= query_type_next;
        query_class         <= query_class_next;
      end
    end
  end

`ifndef SYNTH
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= PW'(MAX_DATAGRAM))
    else $error("byte position ran past the datagram limit");

  a_qend_floor: assert property (@(posedge clk) disable iff (rst)
    name_done |-> question_end >= PW'(HDR_LEN + QUESTION_TAIL))
    else $error("question end below the first possible value");

  a_label_floor: assert property (@(posedge clk) disable iff (rst)
    !name_done |-> next_label_position >= PW'(HDR_LEN))
    else $error("label position inside the header");
`endif

endmodule

// ----- rtl/dsr_emitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsr_emitter
// Holds one job and plays out its result beats: the byte write, if it has one,
// then the drop, send, or ANCOUNT patch plus answer record plus send.
// ----------------------------------------------------------------------------
module dsr_emitter (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  dsr_pkg::job_t job,
  output logic          job_take,
  input  logic [31:0]   answer_address,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [31:0]   m_tdata,    // [9:0] offset, [17:10] value, [27:18] send_length
  output logic [1:0]    m_tuser,    // [1:0] kind
  output logic          m_tlast     // run_end
);
  import dsr_pkg::*;

  logic              busy;
  job_t              cur;
  logic [BEAT_W-1:0] idx;
  logic [BEAT_W-1:0] count;
  logic [BEAT_W-1:0] j;
  logic [BEAT_W-1:0] jm1;
  logic              last;

  kind_t               kind;
  logic [OFFSET_W-1:0] offset;
  logic [7:0]          value;
  logic [OFFSET_W-1:0] send_length;

  always_comb begin
    case (cur.action)
      ACT_ANSWER: count = BEAT_W'(ANSWER_BEATS);
      ACT_DROP,
      ACT_SEND:   count = BEAT_W'(1);
      default:    count = '0;
    endcase
    count = count + BEAT_W'(cur.has_write);
  end

  assign last     = (idx == count - BEAT_W'(1));
  assign job_take = !busy || (m_tready && last);

  always_comb begin
    j           = idx - BEAT_W'(cur.has_write);
    jm1         = j - BEAT_W'(1);
    kind        = KIND_WRITE;
    offset      = '0;
    value       = '0;
    send_length = '0;
    if (cur.has_write && idx == '0) begin
      offset = cur.wr_offset;
      value  = cur.wr_value;
    end else begin
      case (cur.action)
        ACT_DROP: kind = KIND_DROP;
        ACT_SEND: begin
          kind        = KIND_SEND;
          send_length = cur.q_end;
        end
        ACT_ANSWER: begin
          if (j == '0) begin
            offset = OFFSET_W'(ANCOUNT_LO_OFF);
            value  = 8'd1;
          end else if (j == BEAT_W'(ANSWER_BEATS - 1)) begin
            kind        = KIND_SEND;
            send_length = cur.q_end + OFFSET_W'(ANSWER_LEN);
          end else begin
            offset = cur.q_end + OFFSET_W'(jm1);
            value  = answer_byte(jm1[3:0], answer_address);
          end
        end
        default: kind = KIND_WRITE;
      endcase
    end
  end

  assign m_tvalid = busy;
  assign m_tdata  = {4'b0, send_length, value, offset};
  assign m_tuser  = kind;
  assign m_tlast  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (job_take) begin
      busy <= job_valid;
      idx  <= '0;
      if (job_valid) cur <= job;
    end else if (m_tready) begin
      idx <= idx + BEAT_W'(1);
    end
  end

`ifndef SYNTH
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < count)
    else $error("beat index past the end of the job");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (busy && m_tuser != KIND_WRITE) |-> m_tlast)
    else $error("send or drop beat not closing the run");

  a_load: assert property (@(posedge clk) disable iff (rst)
    (job_take && job_valid) |=> (busy && idx == '0))
    else $error("job load did not restart the beat count");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DNS sinkhole responder.
// ----------------------------------------------------------------------------
// Streams query datagrams into the responder and checks every write, send and
// drop beat it emits. The expected beats come from a byte-level rewrite of
// the query kept in the bench. A short directed table covers the header
// rewrite, short datagrams and an answered A query. Shaped random traffic
// follows: well-formed queries of every type and class, cut-off questions,
// noise and stray label lengths. Both handshakes stall at random, and the
// answer address is changed between runs.
// ----------------------------------------------------------------------------
module tb_top;
  import dsr_pkg::*;

  localparam int MAX_DGRAM = 584;
  localparam int SETTLE    = 40;
  localparam int LIMIT     = 500000;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    kind_t       kind;
    logic [9:0]  offset;
    logic [7:0]  value;
    logic [9:0]  send_len;
    logic        run_end;
  } beat_t;

  // One input byte, with up to two typed expectations for rows whose beats
  // can be read straight off the spec.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [1:0]  n_typed;
    beat_t       exp_a;
    beat_t       exp_b;
  } feed_t;

  localparam beat_t NO_BEAT = '0;

  localparam feed_t DIRECTED [22] = '{
    // short datagram: header rewrite on the way, then drop
    '{8'hFF, 1'b0, 2'd1, '{KIND_WRITE, 10'd0, 8'hFF, 10'd0, 1'b1}, NO_BEAT},
    '{8'h00, 1'b0, 2'd1, '{KIND_WRITE, 10'd1, 8'h00, 10'd0, 1'b1}, NO_BEAT},
    '{8'h00, 1'b0, 2'd1, '{KIND_WRITE, 10'd2, FLAGS_HI, 10'd0, 1'b1}, NO_BEAT},
    '{8'hFF, 1'b1, 2'd2, '{KIND_WRITE, 10'd3, FLAGS_LO, 10'd0, 1'b0},
                         '{KIND_DROP, 10'd0, 8'h00, 10'd0, 1'b1}},
    // single-byte datagram
    '{8'h5A, 1'b1, 2'd2, '{KIND_WRITE, 10'd0, 8'h5A, 10'd0, 1'b0},
                         '{KIND_DROP, 10'd0, 8'h00, 10'd0, 1'b1}},
    // A query for the root name, counts all ones on input
    '{8'hBE, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hEF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h01, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h00, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'hFF, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h00, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h00, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h01, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h00, 1'b0, 2'd0, NO_BEAT, NO_BEAT},
    '{8'h01, 1'b1, 2'd0, NO_BEAT, NO_BEAT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'h0;

  dns_sinkhole_responder #(.MAX_DATAGRAM(MAX_DGRAM)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Rewrite state mirrored from the block
  logic [31:0] answer_addr = 32'h0;
  int          pos = 0;
  int          label_at = HDR_LEN;
  bit          root_seen = 1'b0;
  int          q_end = 0;
  logic [15:0] qtype = 16'h0;
  logic [15:0] qclass = 16'h0;

  beat_t       byte_beats[$];
  beat_t       awaited_beats[$];
  feed_t       query_bytes[$];
  logic [7:0]  dgram[$];

  feed_t       cur = '0;
  feed_t       nxt;
  bit          s_took = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;
  int          cycles = 0;
  int          errors = 0;

  // Work out the beats one accepted byte causes, in emit order.
  function automatic void rewrite_byte(logic [7:0] b, logic fin);
    int          p;
    logic [7:0]  v;
    bit          wr;
    logic [7:0]  rec[16];
    byte_beats.delete();
    if (pos < MAX_DGRAM) begin
      p = pos;
      v = b;
      wr = 1'b1;
      if (p < HDR_LEN) begin
        if (p == FLAGS_HI_OFF) v = FLAGS_HI;
        else if (p == FLAGS_LO_OFF) v = FLAGS_LO;
        else if (p == QDCOUNT_LO_OFF) v = 8'h01;
        else if (p >= COUNTS_OFF) v = 8'h00;
      end else if (!root_seen) begin
        if (p == label_at) begin
          if (b == 8'h00) begin
            root_seen = 1'b1;
            q_end = p + QUESTION_TAIL;
          end else begin
            label_at = p + b + 1;
          end
        end
      end else if (p < q_end) begin
        if (q_end - p == 4) qtype[15:8] = b;
        else if (q_end - p == 3) qtype[7:0] = b;
        else if (q_end - p == 2) qclass[15:8] = b;
        else qclass[7:0] = b;
      end else begin
        wr = 1'b0;
      end
      if (wr) byte_beats.push_back('{KIND_WRITE, 10'(p), v, 10'd0, 1'b0});
      pos = p + 1;
    end
    if (fin) begin
      if (pos < HDR_LEN || !root_seen || q_end > pos) begin
        byte_beats.push_back('{KIND_DROP, 10'd0, 8'h00, 10'd0, 1'b0});
      end else if ((qtype == TYPE_A || qtype == TYPE_ANY) && qclass == CLASS_IN) begin
        rec = '{PTR_HI, PTR_LO, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
                TTL_SEC, 8'h00, RDLEN_A, answer_addr[31:24], answer_addr[23:16],
                answer_addr[15:8], answer_addr[7:0]};
        byte_beats.push_back('{KIND_WRITE, 10'(ANCOUNT_LO_OFF), 8'h01, 10'd0, 1'b0});
        for (int i = 0; i < ANSWER_LEN; i++)
          byte_beats.push_back('{KIND_WRITE, 10'(q_end + i), rec[i], 10'd0, 1'b0});
        byte_beats.push_back('{KIND_SEND, 10'd0, 8'h00, 10'(q_end + ANSWER_LEN), 1'b0});
      end else begin
        byte_beats.push_back('{KIND_SEND, 10'd0, 8'h00, 10'(q_end), 1'b0});
      end
      pos = 0;
      label_at = HDR_LEN;
      root_seen = 1'b0;
      q_end = 0;
      qtype = 16'h0;
      qclass = 16'h0;
    end
    if (byte_beats.size() > 0) byte_beats[byte_beats.size()-1].run_end = 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  // Cycle count, timeout, and the switch between calm and stall-prone stretches
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 200 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycles > LIMIT) begin
      $display("%0t: timeout", $time);
      $display("tb_top: errors");
      $finish;
    end
  end

  // Sender: present the next byte, hold it until taken, then maybe idle
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (query_bytes.size() > 0) begin
        nxt = query_bytes.pop_front();
        cur <= nxt;
        s_tdata <= nxt.data;
        s_tlast <= nxt.last;
        s_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Predict on every accepted input beat, check every accepted output beat
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst) begin
      s_took <= 1'b0;
    end else begin
      s_took <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        rewrite_byte(s_tdata, s_tlast);
        if (cur.n_typed == 2'd0) begin
          foreach (byte_beats[i]) awaited_beats.push_back(byte_beats[i]);
        end else begin
          awaited_beats.push_back(cur.exp_a);
          if (cur.n_typed > 2'd1) awaited_beats.push_back(cur.exp_b);
        end
      end
      if (m_tvalid && m_tready) begin
        got = '{kind_t'(m_tuser), m_tdata[9:0], m_tdata[17:10], m_tdata[27:18], m_tlast};
        if (awaited_beats.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind %0d off %0d val %02h len %0d end %0d",
                   $time, got.kind, got.offset, got.value, got.send_len, got.run_end);
        end else begin
          want = awaited_beats.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind %0d off %0d val %02h len %0d end %0d",
                     $time, want.kind, want.offset, want.value, want.send_len,
                     want.run_end);
            $display("%0t:          actual   kind %0d off %0d val %02h len %0d end %0d",
                     $time, got.kind, got.offset, got.value, got.send_len, got.run_end);
          end
        end
      end
    end
  end

  task automatic start_header();
    dgram.delete();
    repeat (HDR_LEN) dgram.push_back(8'($urandom));
  endtask

  task automatic add_label(input int len);
    dgram.push_back(8'(len));
    repeat (len) dgram.push_back(8'($urandom));
  endtask

  task automatic end_question(input logic [15:0] t, input logic [15:0] c);
    dgram.push_back(8'h00);
    dgram.push_back(t[15:8]);
    dgram.push_back(t[7:0]);
    dgram.push_back(c[15:8]);
    dgram.push_back(c[7:0]);
  endtask

  task automatic queue_datagram();
    foreach (dgram[i])
      query_bytes.push_back('{dgram[i], i == dgram.size() - 1, 2'd0, NO_BEAT, NO_BEAT});
  endtask

  task automatic make_query();
    logic [15:0] t;
    logic [15:0] c;
    start_header();
    repeat ($urandom_range(0, 3)) add_label($urandom_range(1, 6));
    case ($urandom_range(0, 3))
      0: t = TYPE_A;
      1: t = TYPE_ANY;
      2: t = 16'($urandom);
      default: t = {8'($urandom), TYPE_A[7:0]};
    endcase
    case ($urandom_range(0, 3))
      0, 1: c = CLASS_IN;
      2: c = 16'($urandom);
      default: c = {8'($urandom), CLASS_IN[7:0]};
    endcase
    end_question(t, c);
    repeat ($urandom_range(0, 2)) dgram.push_back(8'($urandom));
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int pick;
    int cut;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        make_query();
      end else if (pick < 80) begin
        // cut the question short
        make_query();
        cut = $urandom_range(1, dgram.size() - 1);
        while (dgram.size() > cut) void'(dgram.pop_back());
      end else if (pick < 95) begin
        dgram.delete();
        repeat ($urandom_range(1, 20)) dgram.push_back(8'($urandom));
      end else begin
        // stray label length, often pointing past the end
        start_header();
        dgram.push_back(8'($urandom));
        repeat ($urandom_range(0, 30)) dgram.push_back(8'($urandom));
      end
      sent += dgram.size();
      queue_datagram();
    end
  endtask

  // Drain everything, then let any result-less bytes clear the pipeline.
  task automatic wait_idle();
    while (query_bytes.size() > 0 || s_tvalid || awaited_beats.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_address(input logic [31:0] addr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    answer_addr = addr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, answer address still at its reset value
    foreach (DIRECTED[i]) query_bytes.push_back(DIRECTED[i]);
    wait_idle();

    write_address(32'hFFFF_FFFF);
    random_traffic(45);
    hold_req = 1'b1;
    wait_idle();

    write_address($urandom);
    random_traffic(45);
    wait_idle();

    write_address(32'h0000_0000);
    random_traffic(45);
    wait_idle();

    if (awaited_beats.size() > 0)
      $display("%0t: %0d expected beats never arrived", $time, awaited_beats.size());
    if (errors == 0 && awaited_beats.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- dns_sinkhole_responder.f -----
rtl/dsr_pkg.sv
rtl/dsr_parser.sv
rtl/dsr_emitter.sv
rtl/dns_sinkhole_responder.sv
tb/tb_top.sv
